@@ rtl/core/msns_pkg.sv @@
// Types, codes and the period table of the melody string note sequencer.
package msns_pkg;

	localparam int unsigned FULL_W = 13;
	localparam int unsigned PER_W  = 16;
	localparam int unsigned DUR_W  = 16;

	localparam logic [1:0] MODE_CHAR       = 2'd0;
	localparam logic [1:0] MODE_TONE_START = 2'd1;
	localparam logic [1:0] MODE_TONE_STOP  = 2'd2;
	localparam logic [1:0] MODE_RESTART    = 2'd3;

	localparam logic [1:0] ACT_LOAD    = 2'd0;
	localparam logic [1:0] ACT_SILENCE = 2'd1;
	localparam logic [1:0] ACT_KEEP    = 2'd2;
	localparam logic [1:0] ACT_FINISH  = 2'd3;

	localparam logic [1:0] ARM_NONE = 2'd0;
	localparam logic [1:0] ARM_NOTE = 2'd1;
	localparam logic [1:0] ARM_TONE = 2'd2;

	localparam logic [1:0] ROW_FLAT    = 2'd0;
	localparam logic [1:0] ROW_NATURAL = 2'd1;
	localparam logic [1:0] ROW_SHARP   = 2'd2;

	localparam logic [2:0]         OCT_RESET  = 3'd2;
	localparam logic [FULL_W-1:0]  FULL_RESET = 13'd2000;

	localparam logic [7:0] CH_FLAT   = 8'h62; // b
	localparam logic [7:0] CH_SHARP  = 8'h64; // d
	localparam logic [7:0] CH_DOWN   = 8'h2C; // ,
	localparam logic [7:0] CH_UP     = 8'h27; // '
	localparam logic [7:0] CH_SLUR   = 8'h7E; // ~
	localparam logic [7:0] CH_REST   = 8'h52; // R
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_G      = 8'h47;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_END    = 8'h00;

	typedef enum logic [4:0] {
		PH_NOTE = 5'b00001,
		PH_ALT  = 5'b00010,
		PH_OCT  = 5'b00100,
		PH_DUR  = 5'b01000,
		PH_SEP  = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [1:0]       mode;
		logic [7:0]       char_code;
		logic [PER_W-1:0] tone_period;
		logic [DUR_W-1:0] tone_duration_ms;
	} req_t;

	typedef struct packed {
		logic [1:0]       action;
		logic [PER_W-1:0] period;
		logic [DUR_W-1:0] duration_ms;
		logic [1:0]       arm_timer;
		logic             last;
	} rsp_t;

	function automatic logic [PER_W-1:0] rom_period(input logic [1:0] row,
			input logic [2:0] col);
		logic [1:0] r;
		logic [2:0] c;
		logic [PER_W-1:0] p;
		r = (row == 2'd3) ? ROW_NATURAL : row;
		c = (col == 3'd7) ? 3'd0 : col;
		p = '0;
		case ({r, c})
			{ROW_FLAT, 3'd0}:    p = 16'd20248;
			{ROW_FLAT, 3'd1}:    p = 16'd18039;
			{ROW_FLAT, 3'd2}:    p = 16'd16071;
			{ROW_FLAT, 3'd3}:    p = 16'd15169;
			{ROW_FLAT, 3'd4}:    p = 16'd13514;
			{ROW_FLAT, 3'd5}:    p = 16'd12039;
			{ROW_FLAT, 3'd6}:    p = 16'd10726;
			{ROW_NATURAL, 3'd0}: p = 16'd19111;
			{ROW_NATURAL, 3'd1}: p = 16'd17026;
			{ROW_NATURAL, 3'd2}: p = 16'd15169;
			{ROW_NATURAL, 3'd3}: p = 16'd14317;
			{ROW_NATURAL, 3'd4}: p = 16'd12755;
			{ROW_NATURAL, 3'd5}: p = 16'd11364;
			{ROW_NATURAL, 3'd6}: p = 16'd10124;
			{ROW_SHARP, 3'd0}:   p = 16'd18039;
			{ROW_SHARP, 3'd1}:   p = 16'd16071;
			{ROW_SHARP, 3'd2}:   p = 16'd14317;
			{ROW_SHARP, 3'd3}:   p = 16'd13514;
			{ROW_SHARP, 3'd4}:   p = 16'd12039;
			{ROW_SHARP, 3'd5}:   p = 16'd10726;
			{ROW_SHARP, 3'd6}:   p = 16'd9556;
			default:             p = '0;
		endcase
		return p;
	endfunction

endpackage

@@ rtl/core/msns_core.sv @@
// Character parser, tune state and command generation for one item per cycle while fire is high.
module msns_core #(
	parameter int unsigned OCTAVE_STEPS = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  msns_pkg::req_t                item,
	input  logic [msns_pkg::FULL_W-1:0]   full_note_ms,
	output logic [1:0]                    nres,
	output msns_pkg::rsp_t                res0,
	output msns_pkg::rsp_t                res1
);

	msns_pkg::phase_t phase_q, phase_n;
	logic [2:0]  col_q, col_n;
	logic [1:0]  row_q, row_n;
	logic [2:0]  oct_q, oct_n;
	logic [15:0] base_q, base_n;
	logic [15:0] ntime_q, ntime_n;
	logic        pend_q, pend_n;
	logic        snow_q, snow_n;
	logic [15:0] prev_q, prev_n;
	logic        ovl_q, ovl_n;
	logic [15:0] rest_q, rest_n;

	function automatic logic [2:0] wrap_up(input logic [2:0] o);
		logic [3:0] v;
		v = {1'b0, o} + 4'd1;
		for (int i = 0; i < 8; i++) begin
			if (v >= 4'(OCTAVE_STEPS))
				v = v - 4'(OCTAVE_STEPS);
		end
		return v[2:0];
	endfunction

	always_comb begin
		logic [7:0]  c;
		logic [7:0]  cidx;
		logic        is_char, is_b, is_d, is_oct, is_dig, is_letter;
		logic        st_alt, st_oct, st_dur, st_sep, emit, term_note;
		logic [15:0] np;
		logic [1:0]  act;
		logic [15:0] per;
		logic [3:0]  dsh;
		msns_pkg::rsp_t note_r, fin_r;

		c         = item.char_code;
		is_b      = (c == msns_pkg::CH_FLAT);
		is_d      = (c == msns_pkg::CH_SHARP);
		is_oct    = (c == msns_pkg::CH_DOWN) || (c == msns_pkg::CH_UP);
		is_dig    = (c >= msns_pkg::CH_ZERO) && (c <= msns_pkg::CH_NINE);
		is_letter = (c >= msns_pkg::CH_A) && (c <= msns_pkg::CH_G);
		is_char   = (item.mode == msns_pkg::MODE_CHAR) && (c != msns_pkg::CH_END);
		dsh       = 4'(c - msns_pkg::CH_ZERO);
		cidx      = c - msns_pkg::CH_A + 8'd5;

		phase_n = phase_q;
		col_n   = col_q;
		row_n   = row_q;
		oct_n   = oct_q;
		base_n  = base_q;
		ntime_n = ntime_q;
		pend_n  = pend_q;
		snow_n  = snow_q;
		prev_n  = prev_q;
		ovl_n   = ovl_q;
		rest_n  = rest_q;
		emit      = 1'b0;
		term_note = 1'b0;
		nres      = 2'd0;
		res0      = '0;
		res1      = '0;

		st_alt = (phase_q == msns_pkg::PH_ALT);
		st_oct = (phase_q == msns_pkg::PH_OCT) || (st_alt && !is_b && !is_d);
		st_dur = (phase_q == msns_pkg::PH_DUR) || (st_oct && !is_oct);
		st_sep = (phase_q == msns_pkg::PH_SEP) || (st_dur && !is_dig);

		fin_r        = '0;
		fin_r.action = msns_pkg::ACT_FINISH;
		fin_r.last   = 1'b1;

		case (item.mode)
			msns_pkg::MODE_TONE_START: begin
				rest_n = prev_q;
				ovl_n  = 1'b1;
				nres   = 2'd1;
				res0.action      = msns_pkg::ACT_LOAD;
				res0.period      = item.tone_period;
				res0.duration_ms = item.tone_duration_ms;
				res0.arm_timer   = (item.tone_duration_ms != '0) ? msns_pkg::ARM_TONE
					: msns_pkg::ARM_NONE;
				res0.last        = 1'b1;
			end
			msns_pkg::MODE_TONE_STOP: begin
				ovl_n  = 1'b0;
				rest_n = '0;
				nres   = 2'd1;
				res0.action = (rest_q != '0) ? msns_pkg::ACT_LOAD : msns_pkg::ACT_SILENCE;
				res0.period = rest_q;
				res0.last   = 1'b1;
			end
			msns_pkg::MODE_RESTART: begin
				phase_n = msns_pkg::PH_NOTE;
				oct_n   = msns_pkg::OCT_RESET;
				ntime_n = {3'd0, full_note_ms >> 2};
				pend_n  = 1'b0;
			end
			default: begin
				if (is_char) begin
					if (phase_q == msns_pkg::PH_NOTE) begin
						if (is_letter) begin
							col_n   = (cidx >= 8'd7) ? 3'(cidx - 8'd7) : cidx[2:0];
							snow_n  = pend_q;
							phase_n = msns_pkg::PH_ALT;
						end else if (c == msns_pkg::CH_REST) begin
							base_n  = '0;
							snow_n  = pend_q;
							phase_n = msns_pkg::PH_DUR;
						end
					end else begin
						if (st_alt) begin
							row_n = is_b ? msns_pkg::ROW_FLAT
								: (is_d ? msns_pkg::ROW_SHARP : msns_pkg::ROW_NATURAL);
							phase_n = msns_pkg::PH_OCT;
						end
						if (st_oct) begin
							if (c == msns_pkg::CH_DOWN) begin
								if (oct_q != '0)
									oct_n = oct_q - 3'd1;
							end else if (c == msns_pkg::CH_UP) begin
								oct_n = wrap_up(oct_q);
							end else begin
								base_n = msns_pkg::rom_period(row_n, col_q);
							end
							phase_n = msns_pkg::PH_OCT;
						end
						if (st_dur) begin
							if (is_dig)
								ntime_n = {3'd0, full_note_ms >> dsh};
							phase_n = msns_pkg::PH_SEP;
						end
						if (st_sep) begin
							pend_n  = (c == msns_pkg::CH_SLUR);
							phase_n = msns_pkg::PH_NOTE;
							emit    = 1'b1;
						end
					end
				end else begin
					phase_n = msns_pkg::PH_NOTE;
					if (phase_q != msns_pkg::PH_NOTE) begin
						if (st_alt)
							row_n = msns_pkg::ROW_NATURAL;
						if (st_alt || phase_q == msns_pkg::PH_OCT)
							base_n = msns_pkg::rom_period(row_n, col_q);
						emit      = 1'b1;
						term_note = 1'b1;
					end
				end
			end
		endcase

		np  = base_n >> oct_n;
		act = msns_pkg::ACT_KEEP;
		per = '0;
		if (np != prev_q || !snow_n) begin
			if (ovl_q) begin
				if (emit)
					rest_n = (base_n != '0) ? np : '0;
			end else if (base_n != '0) begin
				act = msns_pkg::ACT_LOAD;
				per = np;
			end else
				act = msns_pkg::ACT_SILENCE;
		end
		note_r.action      = act;
		note_r.period      = per;
		note_r.duration_ms = ntime_n;
		note_r.arm_timer   = msns_pkg::ARM_NOTE;
		note_r.last        = !term_note;

		if (emit) begin
			prev_n = np;
			res0   = note_r;
			res1   = fin_r;
			nres   = term_note ? 2'd2 : 2'd1;
		end else if (item.mode == msns_pkg::MODE_CHAR && !is_char) begin
			res0 = fin_r;
			nres = 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= msns_pkg::PH_NOTE;
			col_q   <= '0;
			row_q   <= msns_pkg::ROW_NATURAL;
			oct_q   <= msns_pkg::OCT_RESET;
			base_q  <= '0;
			ntime_q <= {3'd0, msns_pkg::FULL_RESET >> 2};
			pend_q  <= 1'b0;
			snow_q  <= 1'b0;
			prev_q  <= '0;
			ovl_q   <= 1'b0;
			rest_q  <= '0;
		end else if (fire) begin
			phase_q <= phase_n;
			col_q   <= col_n;
			row_q   <= row_n;
			oct_q   <= oct_n;
			base_q  <= base_n;
			ntime_q <= ntime_n;
			pend_q  <= pend_n;
			snow_q  <= snow_n;
			prev_q  <= prev_n;
			ovl_q   <= ovl_n;
			rest_q  <= rest_n;
		end
	end

endmodule

@@ rtl/core/msns_outq.sv @@
// Four-entry result queue taking up to two results per cycle.
module msns_outq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [1:0]     push_n,
	input  msns_pkg::rsp_t push0,
	input  msns_pkg::rsp_t push1,
	output logic           room,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output msns_pkg::rsp_t rsp
);

	msns_pkg::rsp_t mem [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic       pop;

	assign rsp_valid = (cnt_q != 3'd0);
	assign pop       = rsp_valid && rsp_ready;
	assign room      = (cnt_q <= 3'd2);
	assign rsp       = mem[rp_q];

	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			mem[wp_q] <= push0;
		if (push_n == 2'd2)
			mem[wp_q + 2'd1] <= push1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + push_n;
			rp_q  <= rp_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, push_n} - {2'd0, pop};
		end
	end

endmodule

@@ rtl/core/melody_string_note_sequencer_top.sv @@
// Top level of the melody string note sequencer.
//  channel | dir | payload         | transfer when
//  req     | in  | msns_pkg::req_t | req_valid & req_ready
//  rsp     | out | msns_pkg::rsp_t | rsp_valid & rsp_ready
//  cfg     | in  | full_note_ms    | cfg_valid & cfg_ready
// One item per cycle while the queue has room: an item is registered, then
// parsed and turned combinationally into its results, which go to a four-entry result queue.
// The input register advances only while the queue has room for two results,
// so a stalled rsp channel drops req_ready once three results wait in the
// queue and one more item is held in the input register.
// Reset clears all control state; no clearing pass is needed.
module melody_string_note_sequencer_top #(
	parameter int unsigned OCTAVE_STEPS = 5
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  msns_pkg::req_t              req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output msns_pkg::rsp_t              rsp,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [msns_pkg::FULL_W-1:0] cfg_data
);

	msns_pkg::req_t item_s1;
	logic           valid_s1;
	logic           room, fire;
	logic [1:0]     nres, push_n;
	msns_pkg::rsp_t res0, res1;
	logic [msns_pkg::FULL_W-1:0] full_q;

	assign cfg_ready = 1'b1;
	assign fire      = valid_s1 && room;
	assign req_ready = !valid_s1 || fire;
	assign push_n    = fire ? nres : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			full_q <= msns_pkg::FULL_RESET;
		else if (cfg_valid)
			full_q <= cfg_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (req_ready)
			valid_s1 <= req_valid;
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid)
			item_s1 <= req;
	end

	msns_core #(
		.OCTAVE_STEPS(OCTAVE_STEPS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.item         (item_s1),
		.full_note_ms (full_q),
		.nres         (nres),
		.res0         (res0),
		.res1         (res1)
	);

	msns_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.push0     (res0),
		.push1     (res1),
		.room      (room),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
